// ----- rtl/core/mtlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor telemetry line parser package
// Character codes, register indexes, parser state types and the
// number-field helpers used by the character stage.
// ----------------------------------------------------------------------------
package mtlp_pkg;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_P     = 8'h50;

   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_PORT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_PORT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_REVERSE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_REVERSE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_OFFSET  = 3'd5;

   localparam logic [3:0]  PORT_MAX   = 4'd9;
   localparam logic [2:0]  LINE_MIN   = 3'd5;
   localparam logic [2:0]  PREFIX_LEN = 3'd4;
   localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;

   localparam logic signed [32:0] SPD_LIMIT = 33'sh0_7FFF_FFFF;
   localparam logic signed [33:0] POS_LIMIT = 34'sh0_FFFF_FFFF;

   typedef enum logic [5:0] {
      FP_SEEK1 = 6'b000001,
      FP_AFT1  = 6'b000010,
      FP_SEEK2 = 6'b000100,
      FP_AFT2  = 6'b001000,
      FP_SEEK3 = 6'b010000,
      FP_DONE  = 6'b100000
   } field_type;

   typedef enum logic [3:0] {
      NP_SKIP   = 4'b0001,
      NP_SIGN   = 4'b0010,
      NP_DIGITS = 4'b0100,
      NP_STOP   = 4'b1000
   } nphase_type;

   typedef struct packed {
      nphase_type  phase;
      logic        neg;
      logic [31:0] accum;
      logic        digits;
      logic        ovf;
   } num_type;

   localparam num_type NUM_CLEAR = '{phase: NP_SKIP, neg: 1'b0, accum: 32'd0,
                                     digits: 1'b0, ovf: 1'b0};

   typedef struct packed {
      logic [3:0]         left_port;
      logic [3:0]         right_port;
      logic               left_rev;
      logic               right_rev;
      logic signed [31:0] left_off;
      logic signed [31:0] right_off;
   } cfg_type;

   // one decoded line on its way to the result stage
   typedef struct packed {
      logic               side;
      logic               spd_ok;
      logic signed [32:0] spd;
      logic               pos_ok;
      logic signed [33:0] pos;
      logic signed [31:0] off;
   } dec_type;

   function automatic num_type num_feed(num_type cur, logic [7:0] c);
      num_type     nx;
      logic        digit;
      logic        ws;
      logic        idle;
      logic [35:0] v;
      nx    = cur;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      idle  = ((cur.phase == NP_SKIP) && ws) || (cur.phase == NP_STOP);
      v     = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0} + {32'd0, c[3:0]};
      if (!idle) begin
         if ((cur.phase == NP_SKIP) && ((c == CHAR_PLUS) || (c == CHAR_MINUS))) begin
            nx.neg   = (c == CHAR_MINUS);
            nx.phase = NP_SIGN;
         end else if (!digit) begin
            nx.phase = NP_STOP;
         end else begin
            nx.phase  = NP_DIGITS;
            nx.digits = 1'b1;
            if (!cur.ovf) begin
               if (v > {4'd0, MAG_LIMIT}) begin
                  nx.ovf = 1'b1;
               end else begin
                  nx.accum = v[31:0];
               end
            end
         end
      end
      return nx;
   endfunction

   // field holds digits and fits a signed 32-bit value
   function automatic logic num_ok(num_type n);
      return n.digits && !n.ovf && (n.neg || (n.accum != MAG_LIMIT));
   endfunction

   function automatic logic prefix_match(logic [31:0] prefix, logic [3:0] port);
      return (port <= PORT_MAX) &&
             (prefix == {CHAR_P, CHAR_ZERO + {4'd0, port}, CHAR_C, CHAR_ZERO});
   endfunction

endpackage

// ----- rtl/core/mtlp_parser.sv -----
// ----------------------------------------------------------------------------
// Motor telemetry line parser - character stage
// Registers each received character, walks the line state (prefix, field
// delimiters, number fields) and at its newline hands on a complete line for a configured port, decoded.
// ----------------------------------------------------------------------------
module mtlp_parser
   import mtlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_char,
   output logic       req_stall,
   input  cfg_type    cfg,
   output logic       dec_valid,
   output dec_type    dec,
   input  logic       dec_take
);

   logic              in_vld_ff, in_vld_in;
   logic [7:0]        char_ff, char_in;
   logic [2:0]        line_cnt_ff, line_cnt_in;
   logic [31:0]       prefix_ff, prefix_in;
   field_type         field_ff, field_in;
   num_type           num_ff, num_in;
   logic signed [31:0] held_spd_ff, held_spd_in;
   logic              held_ok_ff, held_ok_in;
   logic              dec_vld_ff, dec_vld_in;
   dec_type           dec_ff, dec_in;

   logic              go;
   logic              accept;
   logic              emit;
   logic              lmatch, rmatch;
   logic              rev;
   logic              pos_ok;
   logic              flip;
   logic signed [33:0] pos_mag;
   logic signed [32:0] held_ext;
   logic signed [31:0] cur_signed;
   num_type           feed;

   assign go        = in_vld_ff && (!dec_vld_ff || dec_take);
   assign req_stall = in_vld_ff && !go;
   assign accept    = req_valid && !req_stall;

   assign feed       = num_feed(num_ff, char_ff);
   assign lmatch     = prefix_match(prefix_ff, cfg.left_port);
   assign rmatch     = prefix_match(prefix_ff, cfg.right_port);
   assign emit       = (line_cnt_ff == LINE_MIN) && (field_ff == FP_DONE) && (lmatch || rmatch);
   assign rev        = lmatch ? cfg.left_rev : cfg.right_rev;
   assign pos_ok     = num_ok(num_ff);
   assign flip       = num_ff.neg ^ rev;
   assign pos_mag    = $signed({2'b00, num_ff.accum});
   assign held_ext   = {held_spd_ff[31], held_spd_ff};
   assign cur_signed = num_ff.neg ? (32'd0 - num_ff.accum) : num_ff.accum;

   always_comb begin
      in_vld_in   = in_vld_ff;
      char_in     = char_ff;
      line_cnt_in = line_cnt_ff;
      prefix_in   = prefix_ff;
      field_in    = field_ff;
      num_in      = num_ff;
      held_spd_in = held_spd_ff;
      held_ok_in  = held_ok_ff;
      dec_vld_in  = dec_vld_ff && !dec_take;
      dec_in      = dec_ff;

      if (accept) begin
         in_vld_in = 1'b1;
         char_in   = req_rx_char;
      end else if (go) begin
         in_vld_in = 1'b0;
      end

      if (go) begin
         if (char_ff == CHAR_NL) begin
            if (emit) begin
               dec_vld_in    = 1'b1;
               dec_in.side   = !lmatch;
               dec_in.spd_ok = held_ok_ff;
               dec_in.spd    = rev ? (33'sd0 - held_ext) : held_ext;
               dec_in.pos_ok = pos_ok;
               dec_in.pos    = !pos_ok ? 34'sd0 : (flip ? (34'sd0 - pos_mag) : pos_mag);
               dec_in.off    = lmatch ? cfg.left_off : cfg.right_off;
            end
            // drop the line state at every newline
            line_cnt_in = 3'd0;
            prefix_in   = 32'd0;
            field_in    = FP_SEEK1;
            num_in      = NUM_CLEAR;
            held_spd_in = 32'sd0;
            held_ok_in  = 1'b0;
         end else begin
            if (line_cnt_ff < PREFIX_LEN) begin
               prefix_in = {prefix_ff[23:0], char_ff};
            end
            if (line_cnt_ff < LINE_MIN) begin
               line_cnt_in = line_cnt_ff + 3'd1;
            end
            case (field_ff)
               FP_SEEK1: begin
                  if (char_ff == CHAR_SPACE) begin
                     field_in = FP_AFT1;
                  end
               end
               FP_AFT1: begin
                  num_in   = feed;
                  field_in = FP_SEEK2;
               end
               FP_SEEK2: begin
                  if (char_ff == CHAR_SPACE) begin
                     // hold the finished speed field, restart the number
                     held_ok_in  = pos_ok;
                     held_spd_in = pos_ok ? cur_signed : 32'sd0;
                     num_in      = NUM_CLEAR;
                     field_in    = FP_AFT2;
                  end else begin
                     num_in = feed;
                  end
               end
               FP_AFT2: begin
                  num_in   = feed;
                  field_in = FP_SEEK3;
               end
               FP_SEEK3: begin
                  if (char_ff == CHAR_SPACE) begin
                     field_in = FP_DONE;
                  end else begin
                     num_in = feed;
                  end
               end
               FP_DONE: begin
                  field_in = FP_DONE;
               end
               default: begin
                  field_in = FP_SEEK1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         line_cnt_ff <= 3'd0;
         prefix_ff   <= 32'd0;
         field_ff    <= FP_SEEK1;
         num_ff      <= NUM_CLEAR;
         held_spd_ff <= 32'sd0;
         held_ok_ff  <= 1'b0;
         dec_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         line_cnt_ff <= line_cnt_in;
         prefix_ff   <= prefix_in;
         field_ff    <= field_in;
         num_ff      <= num_in;
         held_spd_ff <= held_spd_in;
         held_ok_ff  <= held_ok_in;
         dec_vld_ff  <= dec_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      dec_ff  <= dec_in;
   end

   assign dec_valid = dec_vld_ff;
   assign dec       = dec_ff;

endmodule

// ----- rtl/core/mtlp_result.sv -----
// ----------------------------------------------------------------------------
// Motor telemetry line parser - result stage
// Applies the position offset, saturates speed and position and holds the
// result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mtlp_result
   import mtlp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               dec_valid,
   input  dec_type            dec,
   output logic               dec_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_side,
   output logic signed [31:0] rsp_speed,
   output logic               rsp_speed_ok,
   output logic signed [32:0] rsp_position,
   output logic               rsp_position_ok
);

   logic               vld_ff, vld_in;
   logic               side_ff;
   logic signed [31:0] spd_ff, spd_in;
   logic               spd_ok_ff;
   logic signed [32:0] pos_ff, pos_in;
   logic               pos_ok_ff;

   logic signed [33:0] pos_diff;
   logic signed [33:0] off_ext;

   assign dec_take = dec_valid && (!vld_ff || !rsp_stall);
   assign off_ext  = {{2{dec.off[31]}}, dec.off};
   assign pos_diff = dec.pos - off_ext;

   always_comb begin
      vld_in = dec_take || (vld_ff && rsp_stall);

      if (dec.spd > SPD_LIMIT) begin
         spd_in = SPD_LIMIT[31:0];
      end else if (dec.spd < -SPD_LIMIT) begin
         spd_in = -SPD_LIMIT[31:0];
      end else begin
         spd_in = dec.spd[31:0];
      end

      // an invalid position reads as zero, offset not applied
      if (!dec.pos_ok) begin
         pos_in = 33'sd0;
      end else if (pos_diff > POS_LIMIT) begin
         pos_in = POS_LIMIT[32:0];
      end else if (pos_diff < -POS_LIMIT) begin
         pos_in = -POS_LIMIT[32:0];
      end else begin
         pos_in = pos_diff[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_take) begin
         side_ff   <= dec.side;
         spd_ff    <= spd_in;
         spd_ok_ff <= dec.spd_ok;
         pos_ff    <= pos_in;
         pos_ok_ff <= dec.pos_ok;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_side        = side_ff;
   assign rsp_speed       = spd_ff;
   assign rsp_speed_ok    = spd_ok_ff;
   assign rsp_position    = pos_ff;
   assign rsp_position_ok = pos_ok_ff;

endmodule

// ----- rtl/core/motor_telemetry_line_parser.sv -----
// ----------------------------------------------------------------------------
// Motor telemetry line parser
// Decodes wheel telemetry lines from a character stream into side, speed and
// position results, with per-side reversal and position offset.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained while rsp_stall is low.
// Path: an accepted newline beat passes the character register, the decode
//   register and the result register on its way to the result beat.
// Reset: synchronous, active high; clears the line state, all valid flags
//   and the registers to left_port 1, right_port 0, no reversal, zero offsets.
// ----------------------------------------------------------------------------
module motor_telemetry_line_parser
   import mtlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_char,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_side,
   output logic signed [31:0]    rsp_speed,
   output logic                  rsp_speed_ok,
   output logic signed [32:0]    rsp_position,
   output logic                  rsp_position_ok,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    dec_valid;
   dec_type dec;
   logic    dec_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEFT_PORT:     cfg_in.left_port  = csr_wdata[3:0];
            CSR_RIGHT_PORT:    cfg_in.right_port = csr_wdata[3:0];
            CSR_LEFT_REVERSE:  cfg_in.left_rev   = csr_wdata[0];
            CSR_RIGHT_REVERSE: cfg_in.right_rev  = csr_wdata[0];
            CSR_LEFT_OFFSET:   cfg_in.left_off   = $signed(csr_wdata[31:0]);
            CSR_RIGHT_OFFSET:  cfg_in.right_off  = $signed(csr_wdata[31:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_port  <= 4'd1;
         cfg_ff.right_port <= 4'd0;
         cfg_ff.left_rev   <= 1'b0;
         cfg_ff.right_rev  <= 1'b0;
         cfg_ff.left_off   <= 32'sd0;
         cfg_ff.right_off  <= 32'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtlp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_char (req_rx_char),
      .req_stall   (req_stall),
      .cfg         (cfg_ff),
      .dec_valid   (dec_valid),
      .dec         (dec),
      .dec_take    (dec_take)
   );

   mtlp_result u_result (
      .clock           (clock),
      .reset           (reset),
      .dec_valid       (dec_valid),
      .dec             (dec),
      .dec_take        (dec_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_side        (rsp_side),
      .rsp_speed       (rsp_speed),
      .rsp_speed_ok    (rsp_speed_ok),
      .rsp_position    (rsp_position),
      .rsp_position_ok (rsp_position_ok)
   );

endmodule

// ----- rtl/core/mtlp_checker.sv -----
// ----------------------------------------------------------------------------
// Motor telemetry line parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mtlp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_side,
   input  logic signed [31:0] rsp_speed,
   input  logic               rsp_speed_ok,
   input  logic signed [32:0] rsp_position,
   input  logic               rsp_position_ok
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_side) && $stable(rsp_speed)
         && $stable(rsp_speed_ok) && $stable(rsp_position) && $stable(rsp_position_ok))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_speed_ok |-> rsp_speed == 32'sd0)
      else $error("invalid speed not zero");

   a_position_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_position_ok |-> rsp_position == 33'sd0)
      else $error("invalid position not zero");

   // speed saturates symmetrically
   a_speed_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speed != 32'sh8000_0000)
      else $error("speed outside saturation range");

endmodule

bind motor_telemetry_line_parser mtlp_checker u_checker (.*);
